FILE: hdl/hecm_pkg.sv
package hecm_pkg;

  // Event codes that can close a pending command.
  localparam logic [7:0] EVT_CMD_COMPLETE = 8'h0E;
  localparam logic [7:0] EVT_CMD_STATUS   = 8'h0F;

  // Header offsets, counted from the event code byte.
  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_CODE   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CHECK  = POS_W'(5);

  // Kind of each result transfer, carried on tuser.
  typedef enum logic [1:0] {
    VERDICT_RETURN   = 2'd0,
    VERDICT_REJECTED = 2'd1,
    VERDICT_FAILED   = 2'd2,
    VERDICT_ASYNC    = 2'd3
  } verdict_t;

  // One result transfer.
  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

endpackage

FILE: hdl/hci_event_completion_matcher.sv
// Channel  | Direction | Signals                        | Content
// in       | slave     | in_tvalid/in_tready/in_tdata   | one HCI event byte per transfer
// out      | master    | out_tvalid/out_tready/out_tdata| verdict on tuser, byte on tdata,
//          |           | out_tuser/out_tlast            | end of packet result on tlast
// cfg      | write     | cfg_we/cfg_wdata               | awaited command opcode
//
// One byte is taken every cycle while in_tready is high; results are registered.
// The framing state is updated in the same cycle the byte is accepted, so the
// packet parser itself never stalls; only the two-entry output buffer does.
// in_tready drops only while both output buffer entries hold results.
// Reset (rst_n low, synchronous) returns to the start of a packet, clears the
// output buffer and sets the awaited opcode to zero.
module hci_event_completion_matcher
  import hecm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] event_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] data_byte
  output logic [1:0]  out_tuser,  // [1:0] verdict
  output logic        out_tlast
);

  logic [15:0]      opcode_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       code_r, code_nxt;
  logic             matched_r, matched_nxt;
  logic [7:0]       hdr_r [4];

  logic             accept;
  logic [7:0]       in_byte;
  logic             fin;
  logic             res_valid;
  result_t          res;
  logic [15:0]      opc_complete;
  logic [15:0]      opc_status;

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  result_t          out_r, out_nxt;
  result_t          skid_r, skid_nxt;
  logic             pop;

  assign accept  = in_tvalid && in_tready;
  assign in_byte = in_tdata;
  assign fin     = (pos_r == (POS_W'(len_r) + POS_W'(1)));

  // The byte that completes the opcode check sees the earlier header bytes.
  assign opc_complete = {hdr_r[2], hdr_r[1]};
  assign opc_status   = {in_byte, hdr_r[2]};

  // Packet framing and verdict for the byte being accepted.
  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    code_nxt    = code_r;
    matched_nxt = matched_r;
    res_valid   = 1'b0;
    res         = '{verdict: VERDICT_ASYNC, data_byte: code_r, last: 1'b1};
    if (pos_r == POS_CODE) begin
      code_nxt    = in_byte;
      matched_nxt = 1'b0;
      pos_nxt     = POS_LENGTH;
    end else if (pos_r == POS_LENGTH) begin
      len_nxt = in_byte;
      if (in_byte == 8'd0) begin
        res_valid = 1'b1;
        pos_nxt   = POS_CODE;
      end else begin
        pos_nxt = POS_FIRST;
      end
    end else begin
      if (pos_r == POS_CHECK) begin
        if (code_r == EVT_CMD_COMPLETE && opc_complete == opcode_r) begin
          matched_nxt = 1'b1;
          res_valid   = 1'b1;
          res.data_byte = in_byte;
          if (in_byte == 8'd0) begin
            res.verdict = VERDICT_RETURN;
            res.last    = fin;
          end else begin
            res.verdict = VERDICT_REJECTED;
          end
        end else if (code_r == EVT_CMD_STATUS && opc_status == opcode_r &&
                     hdr_r[0] != 8'd0) begin
          matched_nxt   = 1'b1;
          res_valid     = 1'b1;
          res.verdict   = VERDICT_FAILED;
          res.data_byte = hdr_r[0];
        end else begin
          res_valid = fin;
        end
      end else if (matched_r) begin
        // Return bytes stream only after a successful Command Complete.
        if (code_r == EVT_CMD_COMPLETE && hdr_r[3] == 8'd0) begin
          res_valid     = 1'b1;
          res.verdict   = VERDICT_RETURN;
          res.data_byte = in_byte;
          res.last      = fin;
        end
      end else begin
        res_valid = fin;
      end
      pos_nxt = fin ? POS_CODE : pos_r + POS_W'(1);
    end
  end

  // Framing state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= POS_CODE;
      len_r     <= 8'd0;
      code_r    <= 8'd0;
      matched_r <= 1'b0;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      code_r    <= code_nxt;
      matched_r <= matched_nxt;
    end
  end

  // Header bytes two through five are kept for the opcode and status check.
  always_ff @(posedge clk) begin
    if (accept && pos_r >= POS_FIRST && pos_r <= POS_CHECK) begin
      hdr_r[2'(pos_r - POS_FIRST)] <= in_byte;
    end
  end

  // Awaited opcode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_r <= 16'd0;
    end else if (cfg_we) begin
      opcode_r <= cfg_wdata;
    end
  end

  // Two-entry output buffer: out_r is the head, skid_r catches a result
  // produced while the head is stalled.
  assign pop       = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (pop) begin
      out_valid_nxt  = skid_valid_r;
      out_nxt        = skid_r;
      skid_valid_nxt = 1'b0;
    end
    if (accept && res_valid) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.data_byte;
  assign out_tuser  = out_r.verdict;
  assign out_tlast  = out_r.last;

endmodule

FILE: hdl/hecm_checker.sv
module hecm_checker
  import hecm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result transfer holds its content.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result transfer changed while stalled");

  // Rejections, failures and async reports always close their packet.
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != VERDICT_RETURN |-> out_tlast)
    else $error("non-return verdict without tlast");

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  // The skid entry fills only while the head is stalled, so a ready sink
  // never backs up the input.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_tready) |-> in_tready)
    else $error("input stalled although results were being taken");

endmodule

bind hci_event_completion_matcher hecm_checker u_hecm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

FILE: verif/testbench.sv
module testbench
  import hecm_pkg::*;
;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  hci_event_completion_matcher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Event bytes waiting to be sent, and verdicts the parser copy has produced.
  logic [7:0] stream_bytes[$];
  result_t    awaited_results[$];

  // Parser copy: framing state and the awaited opcode as the block sees it.
  logic [POS_W-1:0] byte_pos = POS_CODE;
  logic [7:0]       plen = '0;
  logic [7:0]       ev_code = '0;
  logic [7:0]       hdr[4];
  logic             matched = 1'b0;
  logic [15:0]      awaited_opcode = '0;

  // Traffic shaping, set per phase by the stimulus process.
  int in_idle_pct = 38;
  int out_idle_pct = 38;
  int hold_req = 0;
  int hold_seen = 0;
  int stall_left = 0;

  // Bookkeeping.
  int      errors = 0;
  int      bytes_queued = 0;
  int      packets_queued = 0;
  int      opcode_writes = 0;
  int      quiet_cycles = 0;
  int      verdict_seen[4] = '{0, 0, 0, 0};
  result_t head;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void queue_result(input verdict_t v, input logic [7:0] d, input logic l);
    awaited_results.push_back('{verdict: v, data_byte: d, last: l});
  endfunction

  // Advance the parser copy by one accepted event byte.
  function automatic void parse_event_byte(input logic [7:0] b);
    logic [POS_W-1:0] p;
    logic             fin;
    logic [15:0]      opc_complete;
    logic [15:0]      opc_status;
    p = byte_pos;
    if (p == POS_CODE) begin
      ev_code = b;
      matched = 1'b0;
      byte_pos = POS_LENGTH;
      return;
    end
    if (p == POS_LENGTH) begin
      plen = b;
      if (b == 8'd0) begin
        byte_pos = POS_CODE;
        queue_result(VERDICT_ASYNC, ev_code, 1'b1);
      end else begin
        byte_pos = POS_FIRST;
      end
      return;
    end
    fin = (p == {1'b0, plen} + POS_W'(1));
    if (p <= POS_CHECK)
      hdr[2'(p - POS_FIRST)] = b;
    if (p == POS_CHECK) begin
      // The opcode sits in bytes 3..4 of a Complete and bytes 4..5 of a Status.
      opc_complete = {hdr[2], hdr[1]};
      opc_status = {b, hdr[2]};
      if (ev_code == EVT_CMD_COMPLETE && opc_complete == awaited_opcode) begin
        matched = 1'b1;
        if (b == 8'd0)
          queue_result(VERDICT_RETURN, b, fin);
        else
          queue_result(VERDICT_REJECTED, b, 1'b1);
      end else if (ev_code == EVT_CMD_STATUS && opc_status == awaited_opcode &&
                   hdr[0] != 8'd0) begin
        matched = 1'b1;
        queue_result(VERDICT_FAILED, hdr[0], 1'b1);
      end else if (fin) begin
        queue_result(VERDICT_ASYNC, ev_code, 1'b1);
      end
    end else if (matched) begin
      // Only a successful Complete keeps streaming; a rejected one goes quiet.
      if (ev_code == EVT_CMD_COMPLETE && hdr[3] == 8'd0)
        queue_result(VERDICT_RETURN, b, fin);
    end else if (fin) begin
      queue_result(VERDICT_ASYNC, ev_code, 1'b1);
    end
    byte_pos = fin ? POS_CODE : p + POS_W'(1);
  endfunction

  // Packet builders.
  task automatic push_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic add_complete(input logic [15:0] opc, input logic [7:0] status, input int len);
    packets_queued++;
    push_byte(EVT_CMD_COMPLETE);
    push_byte(8'(len));
    push_byte(8'($urandom));
    push_byte(opc[7:0]);
    push_byte(opc[15:8]);
    push_byte(status);
    repeat (len - 4) push_byte(8'($urandom));
  endtask

  task automatic add_status(input logic [15:0] opc, input logic [7:0] status, input int len);
    packets_queued++;
    push_byte(EVT_CMD_STATUS);
    push_byte(8'(len));
    push_byte(status);
    push_byte(8'($urandom));
    push_byte(opc[7:0]);
    push_byte(opc[15:8]);
    repeat (len - 4) push_byte(8'($urandom));
  endtask

  task automatic add_other(input logic [7:0] code, input int len);
    packets_queued++;
    push_byte(code);
    push_byte(8'(len));
    repeat (len) push_byte(8'($urandom));
  endtask

  // Mostly packets aimed at the awaited opcode, the rest near misses and noise.
  task automatic add_random_packets(input int n_bytes);
    int          stop_at;
    int          pick;
    int          len;
    logic [15:0] miss;
    logic [7:0]  code;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(99);
      miss = awaited_opcode ^ (16'h1 << $urandom_range(15));
      if (pick < 35) begin
        len = ($urandom_range(49) == 0) ? 255 : $urandom_range(4, 14);
        add_complete(awaited_opcode,
                     ($urandom_range(9) < 6) ? 8'h00 : 8'($urandom_range(1, 255)), len);
      end else if (pick < 55) begin
        add_status(awaited_opcode,
                   ($urandom_range(9) < 7) ? 8'($urandom_range(1, 255)) : 8'h00,
                   $urandom_range(4, 8));
      end else if (pick < 65) begin
        add_complete(miss, 8'($urandom), $urandom_range(4, 10));
      end else if (pick < 75) begin
        add_status(miss, 8'($urandom_range(1, 255)), $urandom_range(4, 8));
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0:       code = EVT_CMD_COMPLETE;
          1:       code = EVT_CMD_STATUS;
          default: code = 8'($urandom);
        endcase
        add_other(code, $urandom_range(0, 3));
      end else begin
        add_other(8'($urandom), $urandom_range(0, 10));
      end
    end
  endtask

  // Let the block drain: every byte sent, every verdict back, then a few cycles.
  task automatic wait_drained();
    while (stream_bytes.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_awaited_opcode(input logic [15:0] opc);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= opc;
    @(posedge clk);
    cfg_we <= 1'b0;
    awaited_opcode = opc;
    opcode_writes++;
  endtask

  // Input driver: predicts on every accepted byte, then offers the next one.
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      parse_event_byte(in_tdata);
      stream_bytes.delete(0);
    end
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      // Hold the current transfer until it is taken.
    end else if (stream_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
      in_tvalid <= 1'b1;
      in_tdata <= stream_bytes[0];
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver: random back-pressure plus an occasional long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      stall_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Result monitor: each transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("unexpected result verdict %0d byte %02h last %0b",
                             out_tuser, out_tdata, out_tlast));
      end else begin
        head = awaited_results.pop_front();
        if (out_tuser !== head.verdict)
          flag_error($sformatf("verdict got %0d want %0d", out_tuser, head.verdict));
        if (out_tdata !== head.data_byte)
          flag_error($sformatf("data byte got %02h want %02h", out_tdata, head.data_byte));
        if (out_tlast !== head.last)
          flag_error($sformatf("last got %0b want %0b", out_tlast, head.last));
      end
      verdict_seen[out_tuser]++;
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", awaited_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] split_opc;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty packet, short packet, success, rejection, status failure.
    set_awaited_opcode(16'h0C03);
    add_other(8'hFF, 0);
    add_other(EVT_CMD_COMPLETE, 1);
    add_complete(awaited_opcode, 8'h00, 4);
    add_complete(awaited_opcode, 8'h80, 5);
    add_status(awaited_opcode, 8'h01, 4);
    wait_drained();

    // Highest opcode with random idling on both sides.
    set_awaited_opcode(16'hFFFF);
    add_random_packets(70);
    wait_drained();

    // Opcode zero with no idling at all.
    in_idle_pct = 0;
    out_idle_pct = 0;
    set_awaited_opcode(16'h0000);
    add_random_packets(70);
    wait_drained();

    // Long return streams while the receiver holds off, so the input stalls.
    out_idle_pct = 38;
    set_awaited_opcode(16'($urandom));
    repeat (3) add_complete(awaited_opcode, 8'h00, $urandom_range(30, 50));
    hold_req++;
    wait_drained();

    // Random opcode; the phase ends in the middle of a Complete packet.
    in_idle_pct = 38;
    set_awaited_opcode(16'($urandom));
    add_random_packets(70);
    packets_queued++;
    push_byte(EVT_CMD_COMPLETE);
    push_byte(8'd6);
    push_byte(8'($urandom));
    wait_drained();

    // The new opcode applies to the packet already under way.
    split_opc = 16'($urandom);
    set_awaited_opcode(split_opc);
    push_byte(split_opc[7:0]);
    push_byte(split_opc[15:8]);
    push_byte(8'h00);
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    add_random_packets(70);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d event bytes in %0d packets under %0d opcode settings.",
             bytes_queued, packets_queued, opcode_writes);
    $display("Checked %0d return bytes, %0d rejections, %0d failures, %0d async events.",
             verdict_seen[VERDICT_RETURN], verdict_seen[VERDICT_REJECTED],
             verdict_seen[VERDICT_FAILED], verdict_seen[VERDICT_ASYNC]);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
hdl/hecm_pkg.sv
hdl/hci_event_completion_matcher.sv
hdl/hecm_checker.sv
verif/testbench.sv
